// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on clock, off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge
`define RFSB_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// pre at one edge implies post at the next
`define RFSB_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== rtl/core/rfsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rfsb_pkg
// Shared constants and types of the row feather seam blender.
// ----------------------------------------------------------------------------
`default_nettype none

package rfsb_pkg;

   localparam int ROW_WIDTH = 2048;
   localparam int COL_W     = $clog2(ROW_WIDTH);
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;

   localparam logic [COL_W-1:0] COL_MAX = COL_W'(ROW_WIDTH - 1);

   // 50-bit line store word: flags on top, warped BGR, base BGR (blue lowest)
   typedef struct packed {
      logic                               warped_present;
      logic                               base_present;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]    warped;
      logic [NUM_CHAN-1:0][CHAN_W-1:0]    base;
   } line_word_type;

   typedef struct packed {
      logic [COL_W-1:0] first;
      logic [COL_W-1:0] last;
      logic             has;
   } span_type;

endpackage

`default_nettype wire

// ===== rtl/core/rfsb_if.sv =====
// ----------------------------------------------------------------------------
// rfsb_if
// Channel interfaces: pixel pair input, blended pixel output, register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rfsb_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] base_blue;
   logic [7:0] base_green;
   logic [7:0] base_red;
   logic [7:0] warped_blue;
   logic [7:0] warped_green;
   logic [7:0] warped_red;
   logic       base_present;
   logic       warped_present;
   logic       in_overlap;
   logic       row_last;

   modport source (
      output valid, base_blue, base_green, base_red, warped_blue, warped_green,
             warped_red, base_present, warped_present, in_overlap, row_last,
      input  ready
   );
   modport sink (
      input  valid, base_blue, base_green, base_red, warped_blue, warped_green,
             warped_red, base_present, warped_present, in_overlap, row_last,
      output ready
   );
endinterface

interface rfsb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_blue;
   logic [7:0] out_green;
   logic [7:0] out_red;
   logic       out_valid;
   logic       out_row_last;

   modport source (
      output valid, out_blue, out_green, out_red, out_valid, out_row_last,
      input  ready
   );
   modport sink (
      input  valid, out_blue, out_green, out_red, out_valid, out_row_last,
      output ready
   );
endinterface

interface rfsb_csr_if;
   logic valid;
   logic ready;
   logic warped_on_left;

   modport source (output valid, warped_on_left, input ready);
   modport sink   (input valid, warped_on_left, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rfsb_lane.sv =====
// ----------------------------------------------------------------------------
// rfsb_lane
// One color channel: weighted sum, then restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rfsb_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [rfsb_pkg::CHAN_W-1:0]         warped_val,
   input  logic [rfsb_pkg::CHAN_W-1:0]         base_val,
   input  logic [rfsb_pkg::COL_W-1:0]          num,
   input  logic [rfsb_pkg::COL_W-1:0]          den,
   output logic                                done,
   output logic [rfsb_pkg::CHAN_W-1:0]         quot
);
   import rfsb_pkg::*;

   localparam int PROD_W = COL_W + CHAN_W;
   localparam int REM_W  = PROD_W + 2;
   localparam int STEP_W = $clog2(CHAN_W);

   typedef enum logic [1:0] {L_IDLE, L_MUL, L_SUM, L_DIV} lane_state_type;

   lane_state_type      state_ff;
   logic [CHAN_W-1:0]   w_ff, b_ff, q_ff;
   logic [COL_W-1:0]    num_ff, den_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [REM_W-1:0]    rem_ff, dvs_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                done_ff;

   logic [COL_W-1:0]    rest;
   logic [PROD_W-1:0]   total_in;
   logic                take;

   always_comb begin
      rest     = den_ff - num_ff;
      total_in = prod_ff + PROD_W'(rest) * PROD_W'(b_ff);
      take     = (rem_ff >= dvs_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  w_ff     <= warped_val;
                  b_ff     <= base_val;
                  num_ff   <= num;
                  den_ff   <= den;
                  state_ff <= L_MUL;
               end
            end
            L_MUL: begin
               prod_ff  <= PROD_W'(num_ff) * PROD_W'(w_ff);
               state_ff <= L_SUM;
            end
            L_SUM: begin
               rem_ff   <= {1'b0, total_in, 1'b0} + REM_W'(den_ff);
               dvs_ff   <= REM_W'({den_ff, {CHAN_W{1'b0}}});
               step_ff  <= STEP_W'(CHAN_W - 1);
               state_ff <= L_DIV;
            end
            L_DIV: begin
               if (take) begin
                  rem_ff <= rem_ff - dvs_ff;
               end
               q_ff   <= {q_ff[CHAN_W-2:0], take};
               dvs_ff <= dvs_ff >> 1;
               if (step_ff == '0) begin
                  done_ff  <= 1'b1;
                  state_ff <= L_IDLE;
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rfsb_row_track.sv =====
// ----------------------------------------------------------------------------
// rfsb_row_track
// Column counter and overlap span of the current and the previous row.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rfsb_row_track (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        in_overlap,
   input  logic                        row_last,
   output logic [rfsb_pkg::COL_W-1:0]  col,
   output logic                        row_end,
   output rfsb_pkg::span_type          prev_span,
   output logic                        have_prev
);
   import rfsb_pkg::*;

   logic [COL_W-1:0] col_ff;
   span_type         cur_ff, prev_ff, cur_in;
   logic             have_prev_ff;

   always_comb begin
      row_end = row_last || (col_ff == COL_MAX);
      cur_in  = cur_ff;
      if (in_overlap) begin
         if (!cur_ff.has) begin
            cur_in.first = col_ff;
         end
         cur_in.last = col_ff;
         cur_in.has  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         cur_ff       <= '0;
         prev_ff      <= '0;
         have_prev_ff <= 1'b0;
      end else if (accept) begin
         if (row_end) begin
            prev_ff      <= cur_in;
            have_prev_ff <= 1'b1;
            cur_ff       <= '0;
            col_ff       <= '0;
         end else begin
            cur_ff <= cur_in;
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   assign col       = col_ff;
   assign prev_span = prev_ff;
   assign have_prev = have_prev_ff;

   `RFSB_NEXT(a_row_wrap, accept && row_end, col_ff == '0, "column not cleared at row end")
   `RFSB_NEXT(a_col_step, accept && !row_end, col_ff == $past(col_ff) + 1'b1,
      "column did not advance")
   `RFSB_CHECK(a_span_order, !cur_ff.has || (cur_ff.first <= cur_ff.last),
      "span start after span end")

endmodule

`default_nettype wire

// ===== rtl/core/row_feather_seam_blender_core.sv =====
// ----------------------------------------------------------------------------
// row_feather_seam_blender_core
// Linear feather blend of base and warped pixels, emitted one row late.
//
//   channel   dir  role
//   req_chan  in   base/warped BGR pair, presence, overlap, row end
//   rsp_chan  out  blended pixel of previous row, same column
//   csr_chan  in   warped_on_left register write
//
// One pixel at a time: each transfer passes the accept cycle, the line store
// read, the product and the weighted sum, the 8-step divide in each of the
// three channel lanes, a wait for the lanes to finish and the merge into the
// output register, which waits while rsp_chan holds the previous result.
// A new pixel is taken while the previous result waits in the output register.
// Reset clears row tracking and the register; the line store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module row_feather_seam_blender_core (
   input  logic        clock,
   input  logic        reset,
   rfsb_req_if.sink    req_chan,
   rfsb_rsp_if.source  rsp_chan,
   rfsb_csr_if.sink    csr_chan
);
   import rfsb_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_EMIT} core_state_type;

   core_state_type                   state_ff;
   logic                             wol_ff;
   line_word_type                    line_mem [ROW_WIDTH];
   line_word_type                    rd_ff, wr_word;

   logic                             accept;
   logic [COL_W-1:0]                 col;
   logic                             row_end;
   span_type                         prev_span;
   logic                             have_prev;

   logic                             span_hit;
   logic [COL_W-1:0]                 den_in, num_in;

   logic                             ctx_span_ff, ctx_den_zero_ff, ctx_have_ff, ctx_last_ff;
   logic [COL_W-1:0]                 ctx_num_ff, ctx_den_ff;

   logic [NUM_CHAN-1:0]              lane_done;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]  lane_q;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]  mix_val;

   logic                             rsp_valid_ff, out_valid_ff, out_last_ff;
   logic [NUM_CHAN-1:0][CHAN_W-1:0]  out_ff;
   logic                             out_free;

   assign accept          = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = (state_ff == S_IDLE);
   assign csr_chan.ready  = 1'b1;
   assign out_free        = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      wr_word.warped_present = req_chan.warped_present;
      wr_word.base_present   = req_chan.base_present;
      wr_word.warped         = {req_chan.warped_red, req_chan.warped_green,
                                req_chan.warped_blue};
      wr_word.base           = {req_chan.base_red, req_chan.base_green, req_chan.base_blue};
      span_hit = prev_span.has && (col >= prev_span.first) && (col <= prev_span.last);
      den_in   = prev_span.last - prev_span.first;
      num_in   = wol_ff ? (prev_span.last - col) : (col - prev_span.first);
   end

   rfsb_row_track u_row_track (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_overlap (req_chan.in_overlap),
      .row_last   (req_chan.row_last),
      .col        (col),
      .row_end    (row_end),
      .prev_span  (prev_span),
      .have_prev  (have_prev)
   );

   // read-first line store
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[col] <= wr_word;
         rd_ff         <= line_mem[col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wol_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         wol_ff <= csr_chan.warped_on_left;
      end
   end

   for (genvar i = 0; i < NUM_CHAN; i++) begin : g_lane
      rfsb_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .start      (state_ff == S_READ),
         .warped_val (rd_ff.warped[i]),
         .base_val   (rd_ff.base[i]),
         .num        (ctx_num_ff),
         .den        (ctx_den_ff),
         .done       (lane_done[i]),
         .quot       (lane_q[i])
      );
   end

   // merge lane results with pass-through and edge cases
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         if (!ctx_have_ff) begin
            mix_val[i] = '0;
         end else if (ctx_span_ff) begin
            if (ctx_den_zero_ff) begin
               mix_val[i] = wol_ff ? rd_ff.warped[i] : rd_ff.base[i];
            end else begin
               mix_val[i] = lane_q[i];
            end
         end else if (rd_ff.warped_present) begin
            mix_val[i] = rd_ff.warped[i];
         end else if (rd_ff.base_present) begin
            mix_val[i] = rd_ff.base[i];
         end else begin
            mix_val[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ctx_span_ff     <= span_hit;
                  ctx_den_zero_ff <= (den_in == '0);
                  ctx_num_ff      <= num_in;
                  ctx_den_ff      <= den_in;
                  ctx_have_ff     <= have_prev;
                  ctx_last_ff     <= row_end;
                  state_ff        <= S_READ;
               end
            end
            S_READ: state_ff <= S_CALC;
            S_CALC: begin
               if (lane_done[0]) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (out_free) begin
                  out_ff       <= mix_val;
                  out_valid_ff <= ctx_have_ff;
                  out_last_ff  <= ctx_last_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.out_blue     = out_ff[0];
   assign rsp_chan.out_green    = out_ff[1];
   assign rsp_chan.out_red      = out_ff[2];
   assign rsp_chan.out_valid    = out_valid_ff;
   assign rsp_chan.out_row_last = out_last_ff;

   `RFSB_NEXT(a_accept_read, accept, state_ff == S_READ, "transfer did not start a read")
   `RFSB_CHECK(a_lane_lockstep, !lane_done[0] || (&lane_done), "lanes out of step")
   `RFSB_NEXT(a_emit_loads, (state_ff == S_EMIT) && out_free, rsp_valid_ff,
      "result not loaded into output register")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for row_feather_seam_blender_core. A queue of pixel pairs feeds a
// clocked driver that sends them in bursts; each transfer is run through a
// local feather-blend predictor whose expected pixel waits in a queue. A
// clocked monitor compares each output transfer field by field. The receiver
// stalls on its own pattern, with one long hold-off. The warped_on_left
// register is rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rfsb_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1500;
   localparam int PHASE_ITEMS  = 250;
   localparam int HOLD_AT      = 700;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [7:0] base_blue;
      logic [7:0] base_green;
      logic [7:0] base_red;
      logic [7:0] warped_blue;
      logic [7:0] warped_green;
      logic [7:0] warped_red;
      logic       base_present;
      logic       warped_present;
      logic       in_overlap;
      logic       row_last;
   } pixel_pair_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       valid;
      logic       row_last;
   } blend_pixel_type;

   logic clock;
   logic reset = 1'b1;

   rfsb_req_if req_if ();
   rfsb_rsp_if rsp_if ();
   rfsb_csr_if csr_if ();

   row_feather_seam_blender_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // driven values
   logic           req_valid = 1'b0;
   pixel_pair_type req_item  = '0;
   logic           rsp_ready = 1'b0;
   logic           csr_valid = 1'b0;
   logic           csr_wol   = 1'b0;

   assign req_if.valid          = req_valid;
   assign req_if.base_blue      = req_item.base_blue;
   assign req_if.base_green     = req_item.base_green;
   assign req_if.base_red       = req_item.base_red;
   assign req_if.warped_blue    = req_item.warped_blue;
   assign req_if.warped_green   = req_item.warped_green;
   assign req_if.warped_red     = req_item.warped_red;
   assign req_if.base_present   = req_item.base_present;
   assign req_if.warped_present = req_item.warped_present;
   assign req_if.in_overlap     = req_item.in_overlap;
   assign req_if.row_last       = req_item.row_last;
   assign rsp_if.ready          = rsp_ready;
   assign csr_if.valid          = csr_valid;
   assign csr_if.warped_on_left = csr_wol;

   pixel_pair_type  pending_q [$];
   blend_pixel_type blended_q [$];
   int              mismatches  = 0;
   int              pixels_sent = 0;

   // predictor state
   line_word_type    row_mem [ROW_WIDTH];
   logic [COL_W-1:0] col_now     = '0;
   span_type         cur_span    = '0;
   span_type         prev_span   = '0;
   logic             have_prev   = 1'b0;
   logic             wol_setting = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic blend_pixel_type blend_and_store(pixel_pair_type p);
      blend_pixel_type      r;
      logic [COL_W-1:0]     col;
      logic                 row_end;
      line_word_type        word;
      logic [2:0][7:0]      lanes;
      logic [7:0]           bch;
      logic [7:0]           wch;
      int unsigned          num;
      int unsigned          den;
      int unsigned          total;
      col     = col_now;
      row_end = p.row_last || (col == COL_MAX);
      r       = '0;
      lanes   = '0;
      if (have_prev) begin
         word = row_mem[col];
         for (int c = 0; c < NUM_CHAN; c++) begin
            bch = word.base[c];
            wch = word.warped[c];
            if (prev_span.has && col >= prev_span.first && col <= prev_span.last) begin
               den = prev_span.last - prev_span.first;
               if (den == 0) begin
                  lanes[c] = wol_setting ? wch : bch;
               end else begin
                  num = wol_setting ? (prev_span.last - col) : (col - prev_span.first);
                  total = num * wch + (den - num) * bch;
                  lanes[c] = 8'((2 * total + den) / (2 * den));
               end
            end else if (word.warped_present) begin
               lanes[c] = wch;
            end else if (word.base_present) begin
               lanes[c] = bch;
            end else begin
               lanes[c] = 8'h00;
            end
         end
         r.blue  = lanes[0];
         r.green = lanes[1];
         r.red   = lanes[2];
         r.valid = 1'b1;
      end
      r.row_last = row_end;

      word.base[0]        = p.base_blue;
      word.base[1]        = p.base_green;
      word.base[2]        = p.base_red;
      word.warped[0]      = p.warped_blue;
      word.warped[1]      = p.warped_green;
      word.warped[2]      = p.warped_red;
      word.base_present   = p.base_present;
      word.warped_present = p.warped_present;
      row_mem[col]        = word;

      if (p.in_overlap) begin
         if (!cur_span.has) cur_span.first = col;
         cur_span.last = col;
         cur_span.has  = 1'b1;
      end
      if (row_end) begin
         prev_span = cur_span;
         have_prev = 1'b1;
         cur_span  = '0;
         col_now   = '0;
      end else begin
         col_now = col + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [7:0] rand_chan();
      case ($urandom_range(0, 7))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom);
         end
      endcase
   endfunction

   // alternating 0/255 pixels, cycling presence flags
   task automatic queue_pattern_row(int len, logic [7:0] ovl_bits, int variant);
      pixel_pair_type p;
      logic [7:0]     hi_lo;
      for (int col = 0; col < len; col++) begin
         hi_lo            = ((col + variant) % 2) ? 8'hFF : 8'h00;
         p.base_blue      = hi_lo;
         p.base_green     = ~hi_lo;
         p.base_red       = hi_lo;
         p.warped_blue    = ~hi_lo;
         p.warped_green   = hi_lo;
         p.warped_red     = ~hi_lo;
         p.base_present   = ((col + variant) % 4) >= 2;
         p.warped_present = ((col + variant) % 2) == 1;
         p.in_overlap     = ovl_bits[col];
         p.row_last       = (col == len - 1);
         pending_q.insert(pending_q.size(), p);
      end
   endtask

   task automatic queue_random_row(int len);
      pixel_pair_type p;
      int             style;
      int             lo;
      int             hi;
      style = $urandom_range(0, 19);
      lo    = $urandom_range(0, len - 1);
      hi    = $urandom_range(lo, len - 1);
      for (int col = 0; col < len; col++) begin
         p.base_blue      = rand_chan();
         p.base_green     = rand_chan();
         p.base_red       = rand_chan();
         p.warped_blue    = rand_chan();
         p.warped_green   = rand_chan();
         p.warped_red     = rand_chan();
         p.base_present   = 1'($urandom_range(0, 1));
         p.warped_present = 1'($urandom_range(0, 1));
         if (style < 5) begin
            p.in_overlap = 1'b0;
         end else if (style < 15) begin
            p.in_overlap = (col >= lo && col <= hi);
         end else if (style < 17) begin
            p.in_overlap = (col == lo);
         end else begin
            p.in_overlap = ($urandom_range(0, 3) == 0);
         end
         if (col != len - 1) begin
            p.row_last = 1'b0;
         end else if (len == ROW_WIDTH) begin
            p.row_last = 1'($urandom_range(0, 1));  // row end forced either way
         end else begin
            p.row_last = 1'b1;
         end
         pending_q.insert(pending_q.size(), p);
      end
   endtask

   task automatic wait_drained();
      while (pending_q.size() != 0 || req_valid || blended_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wol   <= value;
      do @(posedge clock); while (!csr_if.ready);
      wol_setting = value;
      csr_valid  <= 1'b0;
   endtask

   // driver: bursts of random length with random gaps
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin : drive
      logic take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = req_valid && req_if.ready;
         if (take) begin
            blended_q.insert(blended_q.size(), blend_and_store(req_item));
            pixels_sent++;
         end
         if (!req_valid || take) begin
            if (gap_left > 0 || pending_q.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_item  <= pending_q.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 60);
                  gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   int stall_mode = 0;
   int mode_left  = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   always @(posedge clock) begin : receive
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!hold_done && pixels_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_ready <= ($urandom_range(0, 7) != 0);
               end
            endcase
         end
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      blend_pixel_type want;
      if (!reset && rsp_if.valid && rsp_ready) begin
         if (blended_q.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, got blue %0d green %0d red %0d",
                     $time, rsp_if.out_blue, rsp_if.out_green, rsp_if.out_red);
            mismatches++;
         end else begin
            want = blended_q.pop_front();
            check_field("out_blue",     want.blue,     rsp_if.out_blue);
            check_field("out_green",    want.green,    rsp_if.out_green);
            check_field("out_red",      want.red,      rsp_if.out_red);
            check_field("out_valid",    want.valid,    rsp_if.out_valid);
            check_field("out_row_last", want.row_last, rsp_if.out_row_last);
         end
      end
   end

   int cycle_count = 0;

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
   end

   initial begin : sequencer
      int   random_items;
      int   phase_items;
      int   len;
      int   pick;
      logic next_wol;
      random_items = 0;
      next_wol     = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // first row (outputs not valid): full width with forced end, fills the whole
      // line store so that no later row reads an unwritten column
      queue_random_row(ROW_WIDTH);

      // half-way rounding, one-column span, row without overlap,
      // shorter rows, span from column 0
      queue_pattern_row(5, 8'b0000_1110, 0);
      queue_pattern_row(5, 8'b0000_0100, 1);
      queue_pattern_row(5, 8'b0000_0000, 2);
      queue_pattern_row(4, 8'b0000_1001, 3);
      queue_pattern_row(4, 8'b0000_0000, 0);
      wait_drained();

      write_register(next_wol);
      while (random_items < RANDOM_ITEMS) begin
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 85) len = $urandom_range(1, 24);
            else if (pick < 97) len = $urandom_range(25, 200);
            else len = $urandom_range(201, 700);
            queue_random_row(len);
            phase_items  += len;
            random_items += len;
         end
         wait_drained();
         next_wol = ~next_wol;
         write_register(next_wol);
      end
      wait_drained();

      if (mismatches == 0 && blended_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire
